FILE: design/p2xbu_pkg.sv
// ----------------------------------------------------------------------------
// p2xbu_pkg
// Shared widths, codes and the job record for the 2x bilinear upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package p2xbu_pkg;

    localparam int PIX_W          = 8;
    localparam int COORD_W        = 12;
    localparam int DIM_W          = 12;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam logic [DIM_W-1:0] DIM_RESET = 12'd2048;

    // which source row, or pair of source rows, a result row comes from
    typedef enum logic [1:0] {
        RK_EDGE  = 2'd0,
        RK_UPPER = 2'd1,
        RK_LOWER = 2'd2
    } row_kind_t;

    // which column a result takes relative to the source column
    typedef enum logic [1:0] {
        CK_FIRST = 2'd0,
        CK_ODD   = 2'd1,
        CK_EVEN  = 2'd2,
        CK_LAST  = 2'd3
    } col_kind_t;

    // everything needed to emit the results of one source pixel
    typedef struct packed {
        logic [PIX_W-1:0]              pix;
        logic [PIX_W-1:0]              left;
        logic [PIX_W-1:0]              ul;
        logic [PIX_W-1:0]              above;
        row_kind_t [2:0]               row_kind;
        logic [2:0][COORD_W-1:0]       row_num;
        logic [1:0]                    n_rows;
        col_kind_t [2:0]               col_kind;
        logic [2:0][COORD_W-1:0]       col_num;
        logic [1:0]                    n_cols;
    } job_t;

    function automatic logic [PIX_W-1:0] blend(
        input logic [PIX_W-1:0] heavy,
        input logic [PIX_W-1:0] light
    );
        logic [PIX_W+1:0] sum;
        sum = {1'b0, heavy, 1'b0} + {2'b00, heavy} + {2'b00, light};
        return sum[PIX_W+1:2];
    endfunction

endpackage

`default_nettype wire

FILE: design/p2xbu_emit.sv
// ----------------------------------------------------------------------------
// p2xbu_emit
// Walks the result list of one job and feeds the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module p2xbu_emit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    input  p2xbu_pkg::job_t                job,
    output logic                           job_take,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [p2xbu_pkg::COORD_W-1:0]  out_row,
    output logic [p2xbu_pkg::COORD_W-1:0]  out_col,
    output logic [p2xbu_pkg::PIX_W-1:0]    value,
    output logic                           last_of_run
);
    import p2xbu_pkg::*;

    job_t               job_reg;
    logic               job_valid_reg;
    logic [1:0]         ri_reg;
    logic [1:0]         ci_reg;
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic [PIX_W-1:0]   value_reg;
    logic               last_reg;

    row_kind_t          row_k;
    col_kind_t          col_k;
    logic [PIX_W-1:0]   heavy;
    logic [PIX_W-1:0]   light;
    logic               out_free;
    logic               emit;
    logic               row_end;
    logic               col_end;
    logic               run_end;

    assign row_k    = job_reg.row_kind[ri_reg];
    assign col_k    = job_reg.col_kind[ci_reg];
    assign out_free = !out_valid_reg || !result_stall;
    assign emit     = job_valid_reg && out_free;
    assign row_end  = (ri_reg == job_reg.n_rows - 2'd1);
    assign col_end  = (ci_reg == job_reg.n_cols - 2'd1);
    assign run_end  = emit && row_end && col_end;
    assign job_take = !job_valid_reg || run_end;

    always_comb
    begin
        heavy = job_reg.pix;
        light = job_reg.pix;
        case (row_k)
            RK_EDGE:
            begin
                case (col_k)
                    CK_ODD:  begin heavy = job_reg.left; light = job_reg.pix;  end
                    CK_EVEN: begin heavy = job_reg.pix;  light = job_reg.left; end
                    default: begin heavy = job_reg.pix;  light = job_reg.pix;  end
                endcase
            end
            RK_UPPER:
            begin
                case (col_k)
                    CK_ODD:  begin heavy = job_reg.ul;    light = job_reg.pix;  end
                    CK_EVEN: begin heavy = job_reg.above; light = job_reg.left; end
                    default: begin heavy = job_reg.above; light = job_reg.pix;  end
                endcase
            end
            RK_LOWER:
            begin
                case (col_k)
                    CK_ODD:  begin heavy = job_reg.left; light = job_reg.above; end
                    CK_EVEN: begin heavy = job_reg.pix;  light = job_reg.ul;    end
                    default: begin heavy = job_reg.pix;  light = job_reg.above; end
                endcase
            end
            default:
            begin
                heavy = job_reg.pix;
                light = job_reg.pix;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            ri_reg        <= '0;
            ci_reg        <= '0;
        end
        else if (job_valid && job_take)
        begin
            job_valid_reg <= 1'b1;
            ri_reg        <= '0;
            ci_reg        <= '0;
        end
        else if (run_end)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            if (col_end)
            begin
                ci_reg <= '0;
                ri_reg <= ri_reg + 2'd1;
            end
            else
            begin
                ci_reg <= ci_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_take)
        begin
            job_reg <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg <= job_reg.row_num[ri_reg];
            out_col_reg <= job_reg.col_num[ci_reg];
            value_reg   <= blend(heavy, light);
            last_reg    <= row_end && col_end;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign value        = value_reg;
    assign last_of_run  = last_reg;

endmodule

`default_nettype wire

FILE: design/planar_2x_bilinear_upscale.sv
// ----------------------------------------------------------------------------
// planar_2x_bilinear_upscale
// Streaming 2x bilinear upscaler for one 8-bit plane with a one-row buffer.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+------------------------
//  pixel     | in        | pixel_valid / pixel_stall   | pixel
//  result    | out       | result_valid / result_stall | out_row out_col value
//            |           |                             | last_of_run
//  config    | in        | psel penable pwrite pready  | paddr pwdata prdata
//
//  Each source pixel yields 1 to 9 results, about 4 on average, one result
//  per cycle while result_stall is low; the single result port sets the rate.
//  When idle, a pixel goes through the s1 registers, the job register and the output register.
//  The line buffer is read and written at the pixel transaction, one port.
//  Reset clears counters and pipeline flags; the line buffer is not cleared.
//  A stalled result port backs up into pixel_stall once one pixel is queued.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_2x_bilinear_upscale #(
    parameter int MAX_WIDTH  = p2xbu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = p2xbu_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [p2xbu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [p2xbu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [p2xbu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [p2xbu_pkg::PIX_W-1:0]       pixel,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [p2xbu_pkg::COORD_W-1:0]     out_row,
    output logic [p2xbu_pkg::COORD_W-1:0]     out_col,
    output logic [p2xbu_pkg::PIX_W-1:0]       value,
    output logic                              last_of_run
);
    import p2xbu_pkg::*;

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = (XW + 2 > COORD_W) ? XW + 2 : COORD_W;
    localparam int RW = (YW + 2 > COORD_W) ? YW + 2 : COORD_W;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic             cfg_wr;

    logic [XW-1:0]    x_reg;
    logic [YW-1:0]    y_reg;
    logic [PIX_W-1:0] lp_reg;
    logic [PIX_W-1:0] ul_reg;
    logic             x_last;
    logic             y_last;
    logic             accept;

    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] above_reg;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [PIX_W-1:0] s1_left_reg;
    logic [XW-1:0]    s1_x_reg;
    logic [YW-1:0]    s1_y_reg;
    logic             s1_x_last_reg;
    logic             s1_y_last_reg;
    logic             s1_move;

    job_t             job;
    logic             job_take;
    logic [RW-1:0]    y_dbl;
    logic [RW-1:0]    h_dbl_m1;
    logic [CW-1:0]    x_dbl;
    logic [CW-1:0]    w_dbl_m1;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // zero counts as one, anything above the maximum saturates
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

    // input side and raster counters
    assign pixel_stall = s1_valid_reg && !job_take;
    assign accept      = pixel_valid && !pixel_stall;
    assign x_last      = (WW'(x_reg) == w_eff - WW'(1));
    assign y_last      = (HW'(y_reg) == h_eff - HW'(1));
    assign s1_move     = s1_valid_reg && job_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg  <= '0;
            y_reg  <= '0;
            lp_reg <= '0;
        end
        else if (cfg_wr)
        begin
            x_reg  <= '0;
            y_reg  <= '0;
            lp_reg <= '0;
        end
        else if (accept)
        begin
            if (x_last)
            begin
                x_reg  <= '0;
                lp_reg <= '0;
                y_reg  <= y_last ? '0 : y_reg + YW'(1);
            end
            else
            begin
                x_reg  <= x_reg + XW'(1);
                lp_reg <= pixel;
            end
        end
    end

    // line buffer: old value read out while the new pixel goes in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            above_reg       <= line_mem[x_reg];
            line_mem[x_reg] <= pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg    <= pixel;
            s1_left_reg   <= lp_reg;
            s1_x_reg      <= x_reg;
            s1_y_reg      <= y_reg;
            s1_x_last_reg <= x_last;
            s1_y_last_reg <= y_last;
        end
    end

    // upper-left follows the buffer read of the pixel before, in pipeline order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ul_reg <= '0;
        end
        else if (cfg_wr)
        begin
            ul_reg <= '0;
        end
        else if (s1_move)
        begin
            ul_reg <= s1_x_last_reg ? '0 : above_reg;
        end
    end

    // result list of the queued pixel
    assign y_dbl    = RW'(s1_y_reg) << 1;
    assign h_dbl_m1 = (RW'(h_eff) << 1) - RW'(1);
    assign x_dbl    = CW'(s1_x_reg) << 1;
    assign w_dbl_m1 = (CW'(w_eff) << 1) - CW'(1);

    always_comb
    begin
        job       = '0;
        job.pix   = s1_pix_reg;
        job.left  = s1_left_reg;
        job.ul    = ul_reg;
        job.above = above_reg;

        if (s1_y_reg == '0)
        begin
            job.row_kind[0] = RK_EDGE;
            job.row_num[0]  = COORD_W'(y_dbl);
            job.n_rows      = 2'd1;
            if (s1_y_last_reg)
            begin
                job.row_kind[1] = RK_EDGE;
                job.row_num[1]  = COORD_W'(h_dbl_m1);
                job.n_rows      = 2'd2;
            end
        end
        else
        begin
            job.row_kind[0] = RK_UPPER;
            job.row_num[0]  = COORD_W'(y_dbl - RW'(1));
            job.row_kind[1] = RK_LOWER;
            job.row_num[1]  = COORD_W'(y_dbl);
            job.n_rows      = 2'd2;
            if (s1_y_last_reg)
            begin
                job.row_kind[2] = RK_EDGE;
                job.row_num[2]  = COORD_W'(h_dbl_m1);
                job.n_rows      = 2'd3;
            end
        end

        if (s1_x_reg == '0)
        begin
            job.col_kind[0] = CK_FIRST;
            job.col_num[0]  = '0;
            job.n_cols      = 2'd1;
            if (s1_x_last_reg)
            begin
                job.col_kind[1] = CK_LAST;
                job.col_num[1]  = COORD_W'(w_dbl_m1);
                job.n_cols      = 2'd2;
            end
        end
        else
        begin
            job.col_kind[0] = CK_ODD;
            job.col_num[0]  = COORD_W'(x_dbl - CW'(1));
            job.col_kind[1] = CK_EVEN;
            job.col_num[1]  = COORD_W'(x_dbl);
            job.n_cols      = 2'd2;
            if (s1_x_last_reg)
            begin
                job.col_kind[2] = CK_LAST;
                job.col_num[2]  = COORD_W'(w_dbl_m1);
                job.n_cols      = 2'd3;
            end
        end
    end

    p2xbu_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (s1_valid_reg),
        .job          (job),
        .job_take     (job_take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_row      (out_row),
        .out_col      (out_col),
        .value        (value),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

FILE: design/p2xbu_checker.sv
// ----------------------------------------------------------------------------
// p2xbu_checker
// Port-level checks of the upscaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module p2xbu_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pixel_valid,
    input  logic                           pixel_stall,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  logic [p2xbu_pkg::COORD_W-1:0]  out_row,
    input  logic [p2xbu_pkg::COORD_W-1:0]  out_col,
    input  logic [p2xbu_pkg::PIX_W-1:0]    value,
    input  logic                           last_of_run
);
    import p2xbu_pkg::*;

    // reset leaves nothing pending and the input open
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !result_valid && !pixel_stall)
        else $error("result pending or input stalled in reset");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(out_row) && $stable(out_col) && $stable(value) && $stable(last_of_run))
        else $error("stalled result changed");

    // inside one run results go in row order, then column order
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !last_of_run) ##1 (result_valid && !result_stall)
        |-> (out_row > $past(out_row))
            || (out_row == $past(out_row) && out_col > $past(out_col)))
        else $error("results of one run out of order");

endmodule

bind planar_2x_bilinear_upscale p2xbu_checker u_p2xbu_checker (.*);

`default_nettype wire
